[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked in the same cycle, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Implication checked in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/shrl_pkg.sv]
// Types and constants of the sorted hash range lookup unit.
package shrl_pkg;
  localparam int TABLE_DEPTH = 16384;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int MAX_RESULTS = 64;
  localparam int CAP_W = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_APPEND = 2'd1,
    OP_FIND = 2'd2,
    OP_PROBE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_MID,
    PUSH_END,
    PUSH_FLAG
  } push_t;

  typedef struct packed {
    logic  accept;
    logic  srch_rd;
    logic  srch_upd;
    logic  dn_init;
    logic  rd_i;
    logic  i_dec;
    logic  i_inc;
    logic  i_up;
    logic  take;
    logic  trunc_set;
    push_t push;
    logic  flag;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic hit;
    logic in_rng;
    logic below;
    logic above;
    logic i_zero;
    logic i_end;
    logic n_lt_cap;
    logic n_zero;
    logic out_busy;
  } sta_t;
endpackage

[rtl/shrl_datapath.sv]
// Datapath of the lookup unit: entry memory, search registers and result register.
module shrl_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  shrl_pkg::cmd_t             cmd,
  output shrl_pkg::sta_t             sta,
  input  logic [1:0]                 op,
  input  logic [31:0]                entry_hash,
  input  logic [31:0]                entry_time,
  input  logic [31:0]                query_key,
  input  logic [4:0]                 ignore_bits,
  input  logic                       cfg_wr_en,
  input  logic [shrl_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       found,
  output logic [31:0]                match_time,
  output logic [6:0]                 match_count,
  output logic                       truncated,
  output logic                       last
);
  logic [63:0] mem [shrl_pkg::TABLE_DEPTH];
  logic [63:0] rd_data;
  logic [shrl_pkg::CNT_W-1:0] count, lo, hi, i, idx, mid_c;
  logic [shrl_pkg::ADDR_W-1:0] mid, rd_addr;
  logic [31:0] key, start, stop, pend_time, h;
  logic [shrl_pkg::CAP_W-1:0] cap, cap_eff, n;
  logic trunc;

  assign h = rd_data[63:32];
  assign mid_c = lo + ((hi - lo) >> 1);
  assign rd_addr = cmd.srch_rd ? mid_c[shrl_pkg::ADDR_W-1:0] : i[shrl_pkg::ADDR_W-1:0];

  always_comb begin
    if (cap == '0) cap_eff = shrl_pkg::CAP_W'(1);
    else if (cap > shrl_pkg::CAP_W'(shrl_pkg::MAX_RESULTS))
      cap_eff = shrl_pkg::CAP_W'(shrl_pkg::MAX_RESULTS);
    else cap_eff = cap;
  end

  assign sta.lo_lt_hi = lo < hi;
  assign sta.hit = h == key;
  assign sta.in_rng = (h >= start) && (h <= stop);
  assign sta.below = h < start;
  assign sta.above = h > stop;
  assign sta.i_zero = i == '0;
  assign sta.i_end = i >= count;
  assign sta.n_lt_cap = n < cap_eff;
  assign sta.n_zero = n == '0;
  assign sta.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.accept && op == shrl_pkg::OP_APPEND &&
        count < shrl_pkg::CNT_W'(shrl_pkg::TABLE_DEPTH))
      mem[count[shrl_pkg::ADDR_W-1:0]] <= {entry_hash, entry_time};
    if (cmd.srch_rd || cmd.rd_i) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap <= shrl_pkg::CAP_W'(shrl_pkg::MAX_RESULTS);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      if (cmd.accept) begin
        if (op == shrl_pkg::OP_CLEAR) count <= '0;
        else if (op == shrl_pkg::OP_APPEND &&
                 count < shrl_pkg::CNT_W'(shrl_pkg::TABLE_DEPTH))
          count <= count + 1'b1;
      end
      if (cmd.push != shrl_pkg::PUSH_NONE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key <= query_key;
      start <= (query_key >> ignore_bits) << ignore_bits;
      stop <= ((query_key >> ignore_bits) << ignore_bits) |
              ((32'd1 << ignore_bits) - 32'd1);
      lo <= '0;
      hi <= count;
      i <= '0;
    end
    if (cmd.srch_rd) mid <= mid_c[shrl_pkg::ADDR_W-1:0];
    if (cmd.srch_upd) begin
      if (h > key) hi <= shrl_pkg::CNT_W'(mid);
      else lo <= shrl_pkg::CNT_W'(mid) + 1'b1;
    end
    if (cmd.dn_init) begin
      idx <= shrl_pkg::CNT_W'(mid);
      i <= shrl_pkg::CNT_W'(mid);
      n <= '0;
      trunc <= 1'b0;
    end
    if (cmd.i_dec) i <= i - 1'b1;
    if (cmd.i_inc) i <= i + 1'b1;
    if (cmd.i_up) i <= idx + 1'b1;
    if (cmd.take) begin
      pend_time <= rd_data[31:0];
      n <= n + 1'b1;
    end
    if (cmd.trunc_set) trunc <= 1'b1;
    unique case (cmd.push)
      shrl_pkg::PUSH_MID, shrl_pkg::PUSH_END: begin
        found <= 1'b1;
        match_time <= pend_time;
        match_count <= n;
        truncated <= (cmd.push == shrl_pkg::PUSH_END) && (trunc || cmd.trunc_set);
        last <= cmd.push == shrl_pkg::PUSH_END;
      end
      shrl_pkg::PUSH_FLAG: begin
        found <= cmd.flag;
        match_time <= '0;
        match_count <= '0;
        truncated <= 1'b0;
        last <= 1'b1;
      end
      default: begin
      end
    endcase
  end
endmodule

[rtl/shrl_controller.sv]
// Controller state machine sequencing search, neighbour scan and probe walk.
module shrl_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     op,
  output logic           in_stall,
  input  shrl_pkg::sta_t sta,
  output shrl_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_DN_RD, S_DN_CHK, S_UP_RD, S_UP_CHK,
    S_PR_RD, S_PR_CHK, S_FINAL
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.push = shrl_pkg::PUSH_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (op == shrl_pkg::OP_FIND) state_next = S_SRCH_RD;
          else if (op == shrl_pkg::OP_PROBE) state_next = S_PR_RD;
        end
      end
      S_SRCH_RD: begin
        if (sta.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_next = S_SRCH_CHK;
        end else if (!sta.out_busy) begin
          cmd.push = shrl_pkg::PUSH_FLAG;
          state_next = S_IDLE;
        end
      end
      S_SRCH_CHK: begin
        if (sta.hit) begin
          cmd.dn_init = 1'b1;
          state_next = S_DN_RD;
        end else begin
          cmd.srch_upd = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_DN_RD: begin
        cmd.rd_i = 1'b1;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (!sta.in_rng) begin
          cmd.i_up = 1'b1;
          state_next = S_UP_RD;
        end else if (!sta.n_lt_cap) begin
          cmd.trunc_set = 1'b1;
          state_next = S_FINAL;
        end else if (sta.n_zero || !sta.out_busy) begin
          // The previous match goes out only once a newer one is known.
          if (!sta.n_zero) cmd.push = shrl_pkg::PUSH_MID;
          cmd.take = 1'b1;
          if (sta.i_zero) begin
            cmd.i_up = 1'b1;
            state_next = S_UP_RD;
          end else begin
            cmd.i_dec = 1'b1;
            state_next = S_DN_RD;
          end
        end
      end
      S_UP_RD: begin
        if (sta.i_end) state_next = S_FINAL;
        else begin
          cmd.rd_i = 1'b1;
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (!sta.in_rng) state_next = S_FINAL;
        else if (!sta.n_lt_cap) begin
          cmd.trunc_set = 1'b1;
          state_next = S_FINAL;
        end else if (!sta.out_busy) begin
          cmd.push = shrl_pkg::PUSH_MID;
          cmd.take = 1'b1;
          cmd.i_inc = 1'b1;
          state_next = S_UP_RD;
        end
      end
      S_FINAL: begin
        if (!sta.out_busy) begin
          cmd.push = shrl_pkg::PUSH_END;
          state_next = S_IDLE;
        end
      end
      S_PR_RD: begin
        if (!sta.i_end) begin
          cmd.rd_i = 1'b1;
          state_next = S_PR_CHK;
        end else if (!sta.out_busy) begin
          cmd.push = shrl_pkg::PUSH_FLAG;
          state_next = S_IDLE;
        end
      end
      S_PR_CHK: begin
        if (sta.below) begin
          cmd.i_inc = 1'b1;
          state_next = S_PR_RD;
        end else if (!sta.out_busy) begin
          cmd.push = shrl_pkg::PUSH_FLAG;
          cmd.flag = !sta.above;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

[rtl/sorted_hash_range_lookup_unit.sv]
// Top level of the sorted hash range lookup unit.
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_stall   | op, entry_hash, entry_time, query_key, ignore_bits
//  out     | output    | out_valid, out_stall | found, match_time, match_count, truncated, last
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (result_cap)
// Clear and append are carried out without leaving the idle state. Each binary search step
// of a find is one registered memory read and one compare, and each neighbour scanned is a
// read and a check. A probe walks the table from entry zero, one read and one check per entry.
// Synchronous reset empties the table and sets the cap to 64; no clearing pass is needed.
// A stalled output beat holds the scan until it is taken; one beat is buffered.
`include "assert_macros.svh"
module sorted_hash_range_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] entry_hash,
  input  logic [31:0] entry_time,
  input  logic [31:0] query_key,
  input  logic [4:0]  ignore_bits,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] match_time,
  output logic [6:0]  match_count,
  output logic        truncated,
  output logic        last
);
  shrl_pkg::cmd_t cmd;
  shrl_pkg::sta_t sta;

  shrl_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .op(op), .in_stall(in_stall),
    .sta(sta), .cmd(cmd)
  );

  shrl_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sta(sta), .op(op),
    .entry_hash(entry_hash), .entry_time(entry_time), .query_key(query_key),
    .ignore_bits(ignore_bits), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_stall(out_stall), .out_valid(out_valid), .found(found),
    .match_time(match_time), .match_count(match_count), .truncated(truncated),
    .last(last)
  );

  `ASSERT_IMPLY(a_trunc_last, clk, rst, out_valid && truncated, last)
  `ASSERT_IMPLY(a_mid_found, clk, rst, out_valid && !last, found && match_count != 7'd0)
  `ASSERT_IMPLY(a_cap_bound, clk, rst, out_valid, match_count <= 7'd64)
endmodule
